@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent check wrappers, removed from synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, held off during reset
`define OLS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, held off during reset
`define OLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define OLS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define OLS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/ols_pkg.sv @@
// ---------------------------------------------------------------------------
// ols_pkg
// Shared types and constants of the ordered list store.
// ---------------------------------------------------------------------------
package ols_pkg;

	// fixed field widths
	localparam int KIND_W  = 3;
	localparam int POS_W   = 5;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	// request operations
	typedef enum logic [KIND_W-1:0] {
		K_ADD_FRONT    = 3'd0,
		K_ADD_REAR     = 3'd1,
		K_REMOVE_FRONT = 3'd2,
		K_REMOVE_REAR  = 3'd3,
		K_INSERT_AT    = 3'd4,
		K_REMOVE_AT    = 3'd5
	} kind_t;

	// response status
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_OPEN,
		S_CLOSE,
		S_DONE
	} state_t;

	// one request word
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [POS_W-1:0]   position;
		logic [VALUE_W-1:0] value;
	} req_t;

	// one response word
	typedef struct packed {
		logic [VALUE_W-1:0] removed_value;
		status_t            status;
		logic [COUNT_W-1:0] count;
	} res_t;

endpackage

@@ hdl/ols_mem.sv @@
// ---------------------------------------------------------------------------
// ols_mem
// Element store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module ols_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/ols_ctrl.sv @@
// ---------------------------------------------------------------------------
// ols_ctrl
// Request sequencer: decodes a request, then walks the store one element
// a cycle with a single pointer unit to open or close a gap.
// ---------------------------------------------------------------------------
module ols_ctrl #(
	parameter int CAPACITY      = 16,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  ols_pkg::req_t               req,
	output logic                        res_valid,
	input  logic                        res_ready,
	output ols_pkg::res_t               res,
	output logic                        mem_we,
	output logic [$clog2(CAPACITY)-1:0] mem_waddr,
	output logic [ELEMENT_WIDTH-1:0]    mem_wdata,
	output logic                        mem_re,
	output logic [$clog2(CAPACITY)-1:0] mem_raddr,
	input  logic [ELEMENT_WIDTH-1:0]    mem_rdata
);

	import ols_pkg::*;

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	state_t                   state_q, state_d;
	logic [CW-1:0]            cnt_q, cnt_d;
	logic [CW-1:0]            idx_q, idx_d;
	logic [CW-1:0]            ptr_q, ptr_d;
	logic                     pend_q, pend_d;
	logic                     got_q, got_d;
	status_t                  status_q, status_d;
	logic [ELEMENT_WIDTH-1:0] val_q, val_d;
	logic [ELEMENT_WIDTH-1:0] removed_q, removed_d;

	logic                     full, empty;
	logic [CMPW-1:0]          pos_w, cnt_w;
	logic                     ins_bad, rem_bad;
	logic [CW-1:0]            pos_idx;

	// request checks against the current fill
	assign full    = (cnt_q == CW'(CAPACITY));
	assign empty   = (cnt_q == '0);
	assign pos_w   = CMPW'(req.position);
	assign cnt_w   = CMPW'(cnt_q);
	assign ins_bad = (pos_w == '0) || (pos_w > cnt_w + CMPW'(1));
	assign rem_bad = (pos_w == '0) || (pos_w > cnt_w);
	assign pos_idx = CW'(req.position - POS_W'(1));

	// state and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
			got_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_q  <= pend_d;
			got_q   <= got_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q     <= idx_d;
		ptr_q     <= ptr_d;
		status_q  <= status_d;
		val_q     <= val_d;
		removed_q <= removed_d;
	end

	// next state, store walk and response
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		ptr_d     = ptr_q;
		pend_d    = pend_q;
		got_d     = got_q;
		status_d  = status_q;
		val_d     = val_q;
		removed_d = removed_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = val_q;
		mem_re    = 1'b0;
		mem_raddr = '0;
		res_valid = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					removed_d = '0;
					status_d  = ST_OK;
					val_d     = ELEMENT_WIDTH'(req.value);
					pend_d    = 1'b0;
					got_d     = 1'b0;
					state_d   = S_DONE;
					unique case (kind_t'(req.kind))
						K_ADD_FRONT: begin
							if (full) begin
								status_d = ST_FULL;
							end else begin
								idx_d   = '0;
								ptr_d   = cnt_q;
								state_d = S_OPEN;
							end
						end
						K_ADD_REAR: begin
							if (full) begin
								status_d = ST_FULL;
							end else begin
								idx_d   = cnt_q;
								ptr_d   = cnt_q;
								state_d = S_OPEN;
							end
						end
						K_REMOVE_FRONT: begin
							if (empty) begin
								status_d = ST_UNDER;
							end else begin
								idx_d   = '0;
								ptr_d   = '0;
								state_d = S_CLOSE;
							end
						end
						K_REMOVE_REAR: begin
							if (empty) begin
								status_d = ST_UNDER;
							end else begin
								idx_d   = cnt_q - CW'(1);
								ptr_d   = cnt_q - CW'(1);
								state_d = S_CLOSE;
							end
						end
						K_INSERT_AT: begin
							if (ins_bad) begin
								status_d = ST_RANGE;
							end else if (full) begin
								status_d = ST_FULL;
							end else begin
								idx_d   = pos_idx;
								ptr_d   = cnt_q;
								state_d = S_OPEN;
							end
						end
						K_REMOVE_AT: begin
							if (empty) begin
								status_d = ST_UNDER;
							end else if (rem_bad) begin
								status_d = ST_RANGE;
							end else begin
								idx_d   = pos_idx;
								ptr_d   = pos_idx;
								state_d = S_CLOSE;
							end
						end
						default: begin
							status_d = ST_OK;
						end
					endcase
				end
			end

			// move elements up from the tail, then drop the new word in
			S_OPEN: begin
				mem_re    = (ptr_q != idx_q);
				mem_raddr = AW'(ptr_q - CW'(1));
				pend_d    = mem_re;
				if (mem_re) begin
					ptr_d = ptr_q - CW'(1);
				end
				if (pend_q) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(ptr_q + CW'(1));
					mem_wdata = mem_rdata;
				end else if (ptr_q == idx_q) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(idx_q);
					mem_wdata = val_q;
					cnt_d     = cnt_q + CW'(1);
					state_d   = S_DONE;
				end
			end

			// take the word out, then move later elements down
			S_CLOSE: begin
				mem_re    = (ptr_q != cnt_q);
				mem_raddr = AW'(ptr_q);
				pend_d    = mem_re;
				if (mem_re) begin
					ptr_d = ptr_q + CW'(1);
				end
				if (pend_q) begin
					if (!got_q) begin
						removed_d = mem_rdata;
						got_d     = 1'b1;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = AW'(ptr_q - CW'(2));
						mem_wdata = mem_rdata;
					end
				end
				if (!mem_re && !pend_q) begin
					cnt_d   = cnt_q - CW'(1);
					state_d = S_DONE;
				end
			end

			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign req_stall         = (state_q != S_IDLE);
	assign res.removed_value = VALUE_W'(removed_q);
	assign res.status        = status_q;
	assign res.count         = COUNT_W'(cnt_q);

endmodule

@@ hdl/ordered_list_store_core.sv @@
// ---------------------------------------------------------------------------
// ordered_list_store_core
// Bounded ordered list with front, rear and positional add and remove.
// ---------------------------------------------------------------------------
// One request at a time; the input stalls from accept until the response
// word is handed to the output register.
// Front and positional adds and removes shift the store one element per
// cycle, set by the single memory write port; rear adds and removes shift
// nothing. Failed or unused requests go straight to the response.
// Reset clears the element count, the sequencer state and the output
// valid; the store is not cleared and needs no sweep.
module ordered_list_store_core #(
	parameter int CAPACITY      = 16,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [4:0]  position,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] removed_value,
	output logic [1:0]  status,
	output logic [4:0]  count
);

	import ols_pkg::*;

	`include "assert_macros.svh"

	localparam int AW = $clog2(CAPACITY);

	req_t                     req;
	res_t                     res;
	res_t                     res_q;
	logic                     res_valid, res_ready;
	logic                     out_valid_q;
	logic                     mem_we, mem_re;
	logic [AW-1:0]            mem_waddr, mem_raddr;
	logic [ELEMENT_WIDTH-1:0] mem_wdata, mem_rdata;

	assign req.kind     = kind;
	assign req.position = position;
	assign req.value    = value;

	// sequencer
	ols_ctrl #(
		.CAPACITY      (CAPACITY),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req_stall (in_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// element store
	ols_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (ELEMENT_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register: free when empty or being taken
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (res_valid && res_ready) || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign removed_value = res_q.removed_value;
	assign status        = res_q.status;
	assign count         = res_q.count;

	// checks
	`OLS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	`OLS_ASSERT_IMPLY(a_fail_no_word, clk, arst_n, out_valid && (status != ST_OK), removed_value == '0)
	`OLS_ASSERT_IMPLY(a_full_count, clk, arst_n, out_valid && (status == ST_FULL), count == 5'(CAPACITY))
	`OLS_ASSERT_IMPLY(a_write_in_range, clk, arst_n, mem_we, mem_waddr < CAPACITY)

endmodule

@@ bench/ordered_list_store_core_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ordered_list_store_core_tb
// Checks the bounded ordered list against a behavioural list held in the
// bench. A directed opening covers empty, range and rear/front edge cases.
// Random grow, shrink, churn and noise phases follow, with idling on both
// sides, a long output hold-off and sender pauses until the block drains.
// ---------------------------------------------------------------------------
module ordered_list_store_core_tb;

	import ols_pkg::*;

	localparam int LIST_DEPTH   = 16;
	localparam int RANDOM_ITEMS = 1850;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int TAIL_CYCLES  = 40;
	localparam int LONG_HOLD    = 90;

	typedef enum {PH_GROW, PH_SHRINK, PH_CHURN, PH_NOISE} phase_t;

	// one queued request word with its lead-in gap
	typedef struct {
		logic [2:0]  op;
		logic [4:0]  pos;
		logic [31:0] val;
		int          gap;
		bit          drain;
	} list_request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  kind = '0;
	logic [4:0]  position = '0;
	logic [31:0] value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] removed_value;
	logic [1:0]  status;
	logic [4:0]  count;

	list_request_t request_q[$];
	res_t          answer_q[$];

	// behavioural copy of the list
	logic [31:0] list_mem[LIST_DEPTH];
	int          list_len = 0;

	int  gen_len = 0;
	int  request_total = 0;
	int  accepted_count = 0;
	int  result_index = 0;
	int  results_seen = 0;
	int  error_count = 0;
	int  cycle_count = 0;
	bit  word_taken = 1'b0;
	bit  result_taken = 1'b0;

	ordered_list_store_core #(
		.CAPACITY(LIST_DEPTH),
		.ELEMENT_WIDTH(32)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.removed_value(removed_value),
		.status(status),
		.count(count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// apply one request to the list and return the response it should give
	function automatic res_t apply_list_request(logic [2:0] op, logic [4:0] pos,
			logic [31:0] val);
		res_t r;
		int   slot;
		int   k;
		bit   do_open;
		bit   do_close;
		r.removed_value = '0;
		r.status = ST_OK;
		slot = 0;
		do_open = 1'b0;
		do_close = 1'b0;
		case (op)
			K_ADD_FRONT: begin
				if (list_len >= LIST_DEPTH) r.status = ST_FULL;
				else do_open = 1'b1;
			end
			K_ADD_REAR: begin
				if (list_len >= LIST_DEPTH) r.status = ST_FULL;
				else begin
					do_open = 1'b1;
					slot = list_len;
				end
			end
			K_REMOVE_FRONT: begin
				if (list_len == 0) r.status = ST_UNDER;
				else do_close = 1'b1;
			end
			K_REMOVE_REAR: begin
				if (list_len == 0) r.status = ST_UNDER;
				else begin
					do_close = 1'b1;
					slot = list_len - 1;
				end
			end
			K_INSERT_AT: begin
				// range is judged before fullness
				if (pos == 0 || int'(pos) > list_len + 1) r.status = ST_RANGE;
				else if (list_len >= LIST_DEPTH) r.status = ST_FULL;
				else begin
					do_open = 1'b1;
					slot = int'(pos) - 1;
				end
			end
			K_REMOVE_AT: begin
				// empty is judged before range
				if (list_len == 0) r.status = ST_UNDER;
				else if (pos == 0 || int'(pos) > list_len) r.status = ST_RANGE;
				else begin
					do_close = 1'b1;
					slot = int'(pos) - 1;
				end
			end
			default: ;
		endcase
		if (do_open) begin
			for (k = list_len; k > slot; k--)
				list_mem[k] = list_mem[k-1];
			list_mem[slot] = val;
			list_len++;
		end
		if (do_close) begin
			r.removed_value = list_mem[slot];
			for (k = slot; k + 1 < list_len; k++)
				list_mem[k] = list_mem[k+1];
			list_len--;
		end
		r.count = list_len[4:0];
		return r;
	endfunction

	// queue a request word; gen_len follows the count for well-formed positions
	task automatic queue_request(logic [2:0] op, logic [4:0] pos, logic [31:0] val,
			int gap, bit drain);
		list_request_t item;
		item.op = op;
		item.pos = pos;
		item.val = val;
		item.gap = gap;
		item.drain = drain;
		request_q.push_back(item);
		request_total++;
		case (op)
			K_ADD_FRONT, K_ADD_REAR: if (gen_len < LIST_DEPTH) gen_len++;
			K_REMOVE_FRONT, K_REMOVE_REAR: if (gen_len > 0) gen_len--;
			K_INSERT_AT:
				if (pos != 0 && int'(pos) <= gen_len + 1 && gen_len < LIST_DEPTH) gen_len++;
			K_REMOVE_AT:
				if (gen_len > 0 && pos != 0 && int'(pos) <= gen_len) gen_len--;
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want_v);
		error_count++;
		if (error_count <= 40)
			$display("mismatch on word %0d: %s got %0h want %0h",
				result_index, what, got, want_v);
	endtask

	// driver: presents request words at the falling edge
	always @(negedge clk) begin : driver
		list_request_t cur;
		bit            have_cur;
		int            tx_gap_left;
		bit            next_valid;
		if (arst_n && !(in_valid && !word_taken)) begin
			next_valid = 1'b0;
			if (!have_cur && request_q.size() > 0) begin
				cur = request_q.pop_front();
				have_cur = 1'b1;
				tx_gap_left = cur.gap;
			end
			if (have_cur) begin
				if (tx_gap_left > 0)
					tx_gap_left--;
				else if (!(cur.drain && answer_q.size() != 0)) begin
					kind <= cur.op;
					position <= cur.pos;
					value <= cur.val;
					next_valid = 1'b1;
					have_cur = 1'b0;
				end
			end
			in_valid <= next_valid;
		end
	end

	// receiver: draws a hold-off per result word, with a long one twice
	always @(negedge clk) begin : receiver
		int rx_hold_left;
		if (arst_n) begin
			if (result_taken) begin
				results_seen++;
				if (results_seen == 300 || results_seen == 1300)
					rx_hold_left = LONG_HOLD;
				else if ((results_seen % 500) < 120)
					rx_hold_left = 0;
				else
					rx_hold_left = $urandom_range(0, 12);
			end
			if (rx_hold_left > 0) begin
				out_stall <= 1'b1;
				rx_hold_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// monitor: checks result words and predicts accepted requests
	always @(posedge clk) begin : monitor
		res_t want;
		if (arst_n) begin
			cycle_count++;
			if (out_valid && !out_stall) begin
				if (answer_q.size() == 0) begin
					report_mismatch("unexpected word, removed_value", removed_value, '0);
				end else begin
					want = answer_q.pop_front();
					if (removed_value !== want.removed_value)
						report_mismatch("removed_value", removed_value, want.removed_value);
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (count !== want.count)
						report_mismatch("count", count, want.count);
				end
				result_index++;
			end
			if (in_valid && !in_stall) begin
				answer_q.push_back(apply_list_request(kind, position, value));
				accepted_count++;
			end
			word_taken <= in_valid && !in_stall;
			result_taken <= out_valid && !out_stall;
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("ordered_list_store_core_tb: FAIL");
		$finish;
	end

	// stimulus and end of run
	initial begin : stimulus
		phase_t      ph;
		int          pace;
		int          roll;
		int          counted;
		int          n;
		int          gap;
		int          i;
		logic [2:0]  op;
		logic [4:0]  pos;

		// directed opening: empty list, bad positions, value extremes
		queue_request(K_REMOVE_FRONT, 5'd0, 32'h0, 0, 1'b0);
		queue_request(K_REMOVE_REAR, 5'd0, 32'h0, 0, 1'b0);
		queue_request(K_REMOVE_AT, 5'd5, 32'h0, 0, 1'b0);
		queue_request(K_REMOVE_AT, 5'd0, 32'h0, 0, 1'b0);
		queue_request(K_INSERT_AT, 5'd0, 32'h1234_5678, 0, 1'b0);
		queue_request(K_INSERT_AT, 5'd2, 32'h1234_5678, 0, 1'b0);
		queue_request(K_INSERT_AT, 5'd1, 32'hFFFF_FFFF, 0, 1'b0);
		queue_request(K_ADD_FRONT, 5'd31, 32'h0000_0000, 0, 1'b0);
		queue_request(K_ADD_REAR, 5'd0, 32'hA5A5_A5A5, 0, 1'b0);
		queue_request(K_INSERT_AT, 5'd4, 32'h5A5A_5A5A, 0, 1'b0);
		queue_request(K_INSERT_AT, 5'd2, 32'h8000_0001, 0, 1'b0);
		queue_request(K_INSERT_AT, 5'd7, 32'hDEAD_BEEF, 0, 1'b0);
		queue_request(K_REMOVE_AT, 5'd0, 32'h0, 0, 1'b0);
		queue_request(K_REMOVE_AT, 5'd6, 32'h0, 0, 1'b0);
		queue_request(K_REMOVE_AT, 5'd31, 32'h0, 0, 1'b0);
		queue_request(3'd6, 5'd3, 32'hFFFF_FFFF, 0, 1'b0);
		queue_request(3'd7, 5'd31, 32'h0, 0, 1'b0);
		queue_request(K_REMOVE_AT, 5'd5, 32'h0, 0, 1'b0);
		queue_request(K_REMOVE_AT, 5'd3, 32'h0, 0, 1'b0);
		queue_request(K_REMOVE_AT, 5'd1, 32'h0, 0, 1'b0);
		queue_request(K_REMOVE_FRONT, 5'd0, 32'h0, 0, 1'b0);
		queue_request(K_REMOVE_REAR, 5'd0, 32'h0, 0, 1'b0);

		// random phases; noise carries the unused kinds and wild positions
		counted = 0;
		n = 0;
		ph = PH_GROW;
		pace = 0;
		while (counted < RANDOM_ITEMS) begin
			if (n % 64 == 0) begin
				ph = phase_t'($urandom_range(0, 3));
				pace = $urandom_range(0, 2);
			end
			roll = $urandom_range(0, 9);
			case (ph)
				PH_GROW:   op = (roll < 7) ? 3'd0 : 3'd2;
				PH_SHRINK: op = (roll < 7) ? 3'd2 : 3'd0;
				PH_CHURN:  op = (roll < 5) ? 3'd0 : 3'd2;
				default:   op = 3'($urandom_range(0, 7));
			endcase
			// 0 stands for an add kind and 2 for a remove kind outside noise
			if (ph != PH_NOISE) begin
				case ($urandom_range(0, 2))
					0: op = (op == 3'd0) ? K_ADD_FRONT : K_REMOVE_FRONT;
					1: op = (op == 3'd0) ? K_ADD_REAR : K_REMOVE_REAR;
					default: op = (op == 3'd0) ? K_INSERT_AT : K_REMOVE_AT;
				endcase
			end
			roll = $urandom_range(0, 9);
			if (op == K_INSERT_AT && roll != 0 && ph != PH_NOISE)
				pos = 5'($urandom_range(1, gen_len + 1));
			else if (op == K_REMOVE_AT && gen_len > 0 && roll != 0 && ph != PH_NOISE)
				pos = 5'($urandom_range(1, gen_len));
			else
				pos = 5'($urandom_range(0, 31));
			case (pace)
				0: gap = 0;
				1: gap = $urandom_range(0, 12);
				default: gap = $urandom_range(0, 2);
			endcase
			queue_request(op, pos, $urandom(), gap, (n == 700 || n == 1400));
			counted++;
			n++;
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (accepted_count == request_total);
		for (i = 0; i < 5000 && answer_q.size() != 0; i++)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		while (answer_q.size() != 0) begin
			void'(answer_q.pop_front());
			report_mismatch("missing word, count", '0, '0);
		end
		if (error_count == 0)
			$display("ordered_list_store_core_tb: PASS");
		else
			$display("ordered_list_store_core_tb: FAIL");
		$finish;
	end

endmodule

@@ ordered_list_store_core.f @@
+incdir+hdl
hdl/ols_pkg.sv
hdl/ols_mem.sv
hdl/ols_ctrl.sv
hdl/ordered_list_store_core.sv
bench/ordered_list_store_core_tb.sv
